FILE: rtl/sha256_pkg.sv
// sha-256 byte stream hasher: shared types, constants and a rotate function
// no dependencies
package sha256_pkg;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic       init;      // load initial hash, clear count
    logic       wr_byte;   // write byte into block, count if counting
    logic       count;     // advance bit count
    logic [7:0] wr_data;
    logic       start;     // load round vars, clear round index
    logic       round;     // one compression round
    logic       finish;    // add round vars into chaining words
    logic       rot_out;   // rotate chaining words toward output
  } sha_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [5:0] pos;
    logic [5:0] rnd;
  } sha_sts_t;

  localparam logic [255:0] INIT_H = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

FILE: rtl/sha256_datapath.sv
// sha-256 datapath: block and schedule window, bit count, chaining words, round unit
// depends on sha256_pkg
module sha256_datapath import sha256_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  sha_cmd_t    cmd,
  output sha_sts_t    sts,
  output logic [31:0] h_out
);

  logic [63:0] bits;
  logic [31:0] hw [8];
  logic [31:0] rv [8];
  logic [31:0] win [16];
  logic [5:0]  rnd;
  logic [31:0] wt, s0, s1, t1, t2, wnew;
  logic [3:0]  ri;

  assign sts.pos = bits[8:3];
  assign sts.rnd = rnd;
  assign h_out   = hw[0];
  assign ri      = rnd[3:0];

  always_comb begin
    s0   = rotr(win[ri + 4'd1], 7) ^ rotr(win[ri + 4'd1], 18) ^ (win[ri + 4'd1] >> 3);
    s1   = rotr(win[ri + 4'd14], 17) ^ rotr(win[ri + 4'd14], 19) ^ (win[ri + 4'd14] >> 10);
    wnew = s1 + win[ri + 4'd9] + s0 + win[ri];
    wt   = (rnd < 6'd16) ? win[ri] : wnew;
    t1   = rv[7] + (rotr(rv[4], 6) ^ rotr(rv[4], 11) ^ rotr(rv[4], 25))
         + ((rv[4] & rv[5]) ^ (~rv[4] & rv[6])) + ROUND_K[rnd] + wt;
    t2   = (rotr(rv[0], 2) ^ rotr(rv[0], 13) ^ rotr(rv[0], 22))
         + ((rv[0] & rv[1]) ^ (rv[0] & rv[2]) ^ (rv[1] & rv[2]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bits <= '0;
      rnd  <= '0;
      for (int i = 0; i < 8; i++) hw[i] <= INIT_H[255 - 32*i -: 32];
    end else begin
      if (cmd.init) begin
        bits <= '0;
        for (int i = 0; i < 8; i++) hw[i] <= INIT_H[255 - 32*i -: 32];
      end else if (cmd.count) begin
        bits <= bits + 64'd8;
      end
      // bytes land big-endian in the window words
      if (cmd.wr_byte) begin
        unique case (bits[4:3])
          2'd0: win[bits[8:5]][31:24] <= cmd.wr_data;
          2'd1: win[bits[8:5]][23:16] <= cmd.wr_data;
          2'd2: win[bits[8:5]][15:8]  <= cmd.wr_data;
          2'd3: win[bits[8:5]][7:0]   <= cmd.wr_data;
        endcase
      end
      if (cmd.start) begin
        rnd <= '0;
        for (int i = 0; i < 8; i++) rv[i] <= hw[i];
      end else if (cmd.round) begin
        rnd <= rnd + 6'd1;
        win[ri] <= wt;
        rv[7] <= rv[6];
        rv[6] <= rv[5];
        rv[5] <= rv[4];
        rv[4] <= rv[3] + t1;
        rv[3] <= rv[2];
        rv[2] <= rv[1];
        rv[1] <= rv[0];
        rv[0] <= t1 + t2;
      end
      if (cmd.finish) begin
        for (int i = 0; i < 8; i++) hw[i] <= hw[i] + rv[i];
      end else if (cmd.rot_out) begin
        for (int i = 0; i < 7; i++) hw[i] <= hw[i+1];
        hw[7] <= hw[0];
      end
    end
  end

endmodule

FILE: rtl/sha256_ctrl.sv
// sha-256 controller: byte intake, padding sequence, rounds, digest output
// depends on sha256_pkg
module sha256_ctrl import sha256_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  in_word_t  in_data,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output logic [2:0] out_idx,
  input  sha_sts_t  sts,
  output sha_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_RND   = 3'd2;
  localparam logic [2:0] S_FIN   = 3'd3;
  localparam logic [2:0] S_PAD   = 3'd4;
  localparam logic [2:0] S_LEN   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]  state;
  logic        padding;   // in end-of-message sequence
  logic        len_done;  // length bytes already written
  logic [63:0] len;
  logic [2:0]  lcnt;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && !in_data.kind) begin
          cmd.wr_byte = 1'b1;
          cmd.count   = 1'b1;
          cmd.wr_data = in_data.data_byte;
        end else if (in_valid) begin
          cmd.wr_byte = 1'b1;
          cmd.count   = 1'b1;
          cmd.wr_data = PAD_BYTE;
        end
      end
      S_START: cmd.start = 1'b1;
      S_RND:   cmd.round = 1'b1;
      S_FIN:   cmd.finish = 1'b1;
      S_PAD: begin
        cmd.wr_byte = 1'b1;
        cmd.count   = 1'b1;
        cmd.wr_data = 8'h00;
      end
      S_LEN: begin
        cmd.wr_byte = 1'b1;
        cmd.count   = 1'b1;
        cmd.wr_data = len[63 - 8*lcnt -: 8];
      end
      S_OUT: begin
        cmd.rot_out = out_ready && (out_idx != 3'd7);
        cmd.init    = out_ready && (out_idx == 3'd7);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      padding  <= 1'b0;
      len_done <= 1'b0;
      out_idx  <= '0;
      lcnt     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (in_data.kind) begin
              padding <= 1'b1;
            end
            if (sts.pos == 6'd63) begin
              state <= S_START;
            end else if (in_data.kind) begin
              state <= (sts.pos + 6'd1 == LEN_POS) ? S_LEN : S_PAD;
            end
          end
        end
        S_START: state <= S_RND;
        S_RND:   if (sts.rnd == 6'd63) state <= S_FIN;
        S_FIN: begin
          if (len_done) begin
            state    <= S_OUT;
            len_done <= 1'b0;
            padding  <= 1'b0;
          end else if (padding) begin
            state <= S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_PAD: begin
          if (sts.pos == 6'd63) state <= S_START;
          else if (sts.pos == LEN_POS - 6'd1) state <= S_LEN;
        end
        S_LEN: begin
          lcnt <= lcnt + 3'd1;
          if (lcnt == 3'd7) begin
            len_done <= 1'b1;
            state    <= S_START;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // message length kept in its own bit count, which pad and length bytes do not advance
  logic [63:0] msg_bits;
  always_ff @(posedge clk) begin
    if (rst) begin
      msg_bits <= '0;
    end else if (state == S_IDLE && in_valid) begin
      if (in_data.kind) msg_bits <= msg_bits;
      else msg_bits <= msg_bits + 64'd8;
    end else if (cmd.init) begin
      msg_bits <= '0;
    end
  end

  always_comb begin
    len = msg_bits;
  end

endmodule

FILE: rtl/sha256_byte_stream_hasher_unit.sv
// sha-256 byte stream hasher, top level
// depends on sha256_pkg, sha256_ctrl, sha256_datapath
//
// channel | dir | payload    | handshake
// in      | in  | in_word_t  | in_valid / in_ready
// out     | out | out_word_t | out_valid / out_ready
//
// message bytes are taken one per cycle while idle; a byte that fills a block starts a
// compression (load, 64 rounds of the single round unit, final add)
// end of message: pad bytes one per cycle up to position 56, then eight length bytes, one or two blocks
// compressed, then eight digest words, one per accepted output cycle
// rst is synchronous; input is held off while a block compresses, pad bytes are written or words drain
module sha256_byte_stream_hasher_unit import sha256_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  in_word_t  in_data,
  input  logic      in_valid,
  output logic      in_ready,
  output out_word_t out_data,
  output logic      out_valid,
  input  logic      out_ready
);

  sha_cmd_t    cmd;
  sha_sts_t    sts;
  logic [31:0] h_out;
  logic [2:0]  idx;

  sha256_ctrl u_ctrl (
    .clk, .rst, .in_data, .in_valid, .in_ready, .out_valid, .out_ready,
    .out_idx(idx), .sts, .cmd);

  sha256_datapath u_dp (.clk, .rst, .cmd, .sts, .h_out);

  assign out_data.digest_word = h_out;
  assign out_data.word_index  = idx;
  assign out_data.last_word   = (idx == 3'd7);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input and output both open");

  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && idx != 3'd7 |=> out_valid)
    else $error("digest words interrupted");

  a_last_back: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && idx == 3'd7 |=> in_ready)
    else $error("no return to intake after digest");

endmodule

FILE: dv/tb_top.sv
// testbench for the sha-256 byte stream hasher: random and directed byte streams,
// digests predicted by an in-bench sha-256 model and checked word by word
// depends on sha256_pkg and sha256_byte_stream_hasher_unit
module tb_top;
  import sha256_pkg::*;

  class digest_board;
    logic [31:0] hash_st [8];
    logic [7:0]  blk [64];
    logic [63:0] nbits;
    out_word_t   pending [$];
    int          errors;
    int          digests;

    function void restart();
      for (int i = 0; i < 8; i++) hash_st[i] = INIT_H[255 - 32*i -: 32];
      for (int i = 0; i < 64; i++) blk[i] = 8'h00;
      nbits = 64'd0;
    endfunction

    function new();
      errors = 0;
      digests = 0;
      restart();
    endfunction

    function logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      logic [31:0] v [8];
      logic [31:0] w [64];
      logic [31:0] t1, t2;
      for (int i = 0; i < 8; i++) v[i] = hash_st[i];
      for (int i = 0; i < 16; i++) w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      for (int t = 16; t < 64; t++)
        w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7] +
               (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
      for (int t = 0; t < 64; t++) begin
        t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
             ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
        t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
             ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_st[i] += v[i];
    endfunction

    function void note_input(in_word_t wd);
      int p;
      logic [63:0] len;
      out_word_t o;
      p = nbits[8:3];
      if (!wd.kind) begin
        blk[p] = wd.data_byte;
        nbits += 64'd8;
        if (p == 63) compress();
        return;
      end
      len = nbits;
      blk[p] = PAD_BYTE;
      p++;
      if (p > 56) begin
        for (int i = p; i < 64; i++) blk[i] = 8'h00;
        compress();
        p = 0;
      end
      for (int i = p; i < 56; i++) blk[i] = 8'h00;
      for (int i = 0; i < 8; i++) blk[56+i] = len[63 - 8*i -: 8];
      compress();
      for (int i = 0; i < 8; i++) begin
        o.digest_word = hash_st[i];
        o.word_index = i[2:0];
        o.last_word = (i == 7);
        pending.push_back(o);
      end
      restart();
    endfunction

    function void check_output(out_word_t got);
      out_word_t exp_w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (got.digest_word !== exp_w.digest_word) begin
        $display("%0t: digest_word exp %h got %h", $time, exp_w.digest_word, got.digest_word);
        errors++;
      end
      if (got.word_index !== exp_w.word_index) begin
        $display("%0t: word_index exp %0d got %0d", $time, exp_w.word_index, got.word_index);
        errors++;
      end
      if (got.last_word !== exp_w.last_word) begin
        $display("%0t: last_word exp %0d got %0d", $time, exp_w.last_word, got.last_word);
        errors++;
      end
      if (got.last_word === 1'b1) digests++;
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  in_word_t  in_data = '0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  out_word_t out_data;
  logic      out_valid;
  logic      out_ready = 1'b0;

  digest_board board = new();
  bit          calm = 1'b0;
  int          sent = 0;
  int          idle_cycles = 0;

  sha256_byte_stream_hasher_unit i_dut (
    .clk(clk), .rst(rst), .in_data(in_data), .in_valid(in_valid), .in_ready(in_ready),
    .out_data(out_data), .out_valid(out_valid), .out_ready(out_ready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // input side bookkeeping and output checks at the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) board.note_input(in_data);
      if (out_valid && out_ready) board.check_output(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles > 20000) begin
      $display("watchdog expired");
      $display("simulation failed");
      $finish;
    end
  end

  // receiver stalls in bursts
  initial begin
    int n;
    @(posedge clk);
    while (1) begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 6);
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      n = $urandom_range(1, 8);
      repeat (n) @(posedge clk);
    end
  end

  task automatic send_word(logic k, logic [7:0] b);
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      n = $urandom_range(1, 6);
      repeat (n) @(posedge clk);
    end
    in_data <= '{kind: k, data_byte: b};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_message(int len);
    for (int i = 0; i < len; i++) send_word(1'b0, 8'($urandom_range(0, 255)));
    send_word(1'b1, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: empty message, extreme bytes, padding boundaries
    send_word(1'b1, 8'hff);
    send_word(1'b0, 8'h00);
    send_word(1'b0, 8'hff);
    send_word(1'b0, 8'h80);
    send_word(1'b1, 8'h00);
    send_word(1'b0, 8'h55);
    send_word(1'b0, 8'haa);
    send_word(1'b1, 8'haa);
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    send_message(55);
    send_message(56);
    send_message(64);
    while (sent < 330) begin
      case ($urandom_range(0, 3))
        0: send_message($urandom_range(0, 3));
        1: send_message($urandom_range(50, 70));
        default: send_message($urandom_range(0, 40));
      endcase
    end
    calm = 1'b1;
    send_message($urandom_range(0, 30));
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d input words, %0d digests compared", sent, board.digests);
    $display("messages covered empty, block boundary and multi-block lengths");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
